/* hdl/hlpm_pkg.sv */
// shared types, codes and helpers of the prefix hash table
package hlpm_pkg;

    localparam int KEY_W = 32;
    localparam int LEN_W = 6;
    localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_BADLEN = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef enum logic [2:0] {
        OP_LOOKUP,
        OP_INSERT,
        OP_DELETE,
        OP_BADLEN,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] addr;
        logic [LEN_W-1:0] len;
    } qent_t;

    function automatic logic [KEY_W-1:0] high_mask(input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] m;
        if (len == '0)
            m = '0;
        else
            m = {KEY_W{1'b1}} << (MAX_LEN - len);
        return m;
    endfunction

    function automatic logic [KEY_W-1:0] lookup_key(input logic [KEY_W-1:0] addr,
                                                    input logic [LEN_W-1:0] len);
        return (addr & high_mask(len)) - {{(KEY_W-LEN_W){1'b0}}, len};
    endfunction

endpackage

/* hdl/hlpm_if.sv */
// request and response channel interfaces

interface hlpm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [31:0] address;
    logic [5:0] prefix_len;

    modport source (output valid, output mode, output address, output prefix_len,
                    input ready);
    modport sink (input valid, input mode, input address, input prefix_len,
                  output ready);
endinterface

interface hlpm_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [5:0] match_len;

    modport source (output valid, output status, output match_len, input ready);
    modport sink (input valid, input status, input match_len, output ready);
endinterface

/* hdl/ipv4_prefix_hash_lpm.sv */
// top level of the ipv4 prefix hash table with longest-prefix lookup
//
// After reset the block sweeps the slot memory, one slot per cycle, before it
// takes its first request. Requests are classified and queued by the front;
// the back handles one at a time using one write and one read port of the
// slot memory and a shared hash unit. Each hash (key mod CAPACITY-1) is
// followed by a probe walk in which each slot is read and then checked. An
// insert or delete costs one hash and a probe walk (a delete that misses
// probes all CAPACITY slots); a lookup repeats hash plus probe walk for each
// length from 32 down to the first hit, or down to 0 if none hits. Bad lengths
// and unused modes answer without a hash or probe walk. Responses come back in
// request order, and up to two requests queue while one is in work.
module ipv4_prefix_hash_lpm #(
    parameter int CAPACITY = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    hlpm_req_if.sink  req,
    hlpm_rsp_if.source rsp
);
    import hlpm_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_nonempty;
    qent_t q_in;
    qent_t q_out;

    hlpm_front u_front (
        .req    (req),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    hlpm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .nonempty  (q_nonempty),
        .pop_data  (q_out)
    );

    hlpm_back #(.CAPACITY(CAPACITY)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_data     (q_out),
        .q_pop      (q_pop),
        .rsp        (rsp)
    );

endmodule

/* hdl/hlpm_mod.sv */
// key modulo (capacity - 1) by reciprocal multiplication, registered as operand, product, partial and final remainder
module hlpm_mod #(
    parameter int CAPACITY = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [31:0]                  dividend,
    output logic                         done,
    output logic [$clog2(CAPACITY)-1:0]  rem
);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int DIV   = CAPACITY - 1;
    localparam int SHIFT = 31 + $clog2(DIV + 1) - 1;
    localparam logic [31:0] RECIP = 32'((64'd1 << SHIFT) / 64'(DIV));
    localparam logic [31:0] DIVV  = 32'(DIV);

    logic [31:0]      x_reg;
    logic [31:0]      x1_reg;
    logic [63:0]      prod_reg;
    logic [31:0]      r0_reg;
    logic [IDX_W-1:0] rem_reg;
    logic [2:0]       stage_reg;
    logic             done_reg;
    logic [31:0]      quot;

    // estimate is the quotient or one below it
    assign quot = 32'(prod_reg >> SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= {stage_reg[1:0], start};
            done_reg  <= stage_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            x_reg <= dividend;
        prod_reg <= 64'(x_reg) * 64'(RECIP);
        x1_reg   <= x_reg;
        r0_reg   <= x1_reg - quot * DIVV;
        rem_reg  <= IDX_W'((r0_reg >= DIVV) ? r0_reg - DIVV : r0_reg);
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

/* hdl/hlpm_queue.sv */
// two-entry queue between front and back
module hlpm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hlpm_pkg::qent_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          nonempty,
    output hlpm_pkg::qent_t pop_data
);
    import hlpm_pkg::*;

    qent_t      mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

    assign full     = (cnt_reg == 2'd2);
    assign nonempty = (cnt_reg != 2'd0);
    assign pop_data = mem_reg[rp_reg];

endmodule

/* hdl/hlpm_front.sv */
// request intake: classifies each request and forms its key
module hlpm_front (
    hlpm_req_if.sink        req,
    input  logic            q_full,
    output logic            q_push,
    output hlpm_pkg::qent_t q_data
);
    import hlpm_pkg::*;

    always_comb
    begin
        q_data.addr = req.address;
        q_data.len  = req.prefix_len;
        q_data.key  = req.address - {26'b0, req.prefix_len};
        case (req.mode)
            MODE_LOOKUP:
            begin
                q_data.op  = OP_LOOKUP;
                q_data.key = lookup_key(req.address, MAX_LEN);
            end
            MODE_INSERT:
                q_data.op = (req.prefix_len > MAX_LEN) ? OP_BADLEN : OP_INSERT;
            MODE_DELETE:
                q_data.op = (req.prefix_len > MAX_LEN) ? OP_BADLEN : OP_DELETE;
            default:
                q_data.op = OP_NOP;
        endcase
    end

    assign req.ready = !q_full;
    assign q_push    = req.valid && !q_full;

endmodule

/* hdl/hlpm_back.sv */
// table engine: hash, probe walk, slot update and response register
module hlpm_back #(
    parameter int CAPACITY = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_nonempty,
    input  hlpm_pkg::qent_t q_data,
    output logic            q_pop,
    hlpm_rsp_if.source      rsp
);
    import hlpm_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY / 2 + 1);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] HALF = CNT_W'(CAPACITY / 2);
    localparam int WORD_W = 1 + LEN_W + KEY_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MOD   = 6'b000100,
        S_RD    = 6'b001000,
        S_CHK   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [KEY_W-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       status_reg, status_next;
    logic [LEN_W-1:0] mlen_reg, mlen_next;

    logic [WORD_W-1:0] mem [CAPACITY];
    logic [WORD_W-1:0] rd_reg;
    logic              we;
    logic [IDX_W-1:0]  wa;
    logic [WORD_W-1:0] wd;

    logic              mod_start;
    logic [KEY_W-1:0]  mod_din;
    logic              mod_done;
    logic [IDX_W-1:0]  mod_rem;

    logic              rd_v;
    logic [LEN_W-1:0]  rd_len;
    logic [KEY_W-1:0]  rd_key;
    logic              key_hit;
    logic [IDX_W-1:0]  slot_inc;
    logic [LEN_W-1:0]  len_dec;

    hlpm_mod #(.CAPACITY(CAPACITY)) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_din),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign rd_v     = rd_reg[WORD_W-1];
    assign rd_len   = rd_reg[KEY_W +: LEN_W];
    assign rd_key   = rd_reg[KEY_W-1:0];
    assign key_hit  = (rd_key == key_reg);
    assign slot_inc = (slot_reg == LAST) ? '0 : slot_reg + 1'b1;
    assign len_dec  = len_reg - 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        addr_next   = addr_reg;
        len_next    = len_reg;
        slot_next   = slot_reg;
        n_next      = n_reg;
        clr_next    = clr_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        mlen_next   = mlen_reg;
        q_pop       = 1'b0;
        mod_start   = 1'b0;
        mod_din     = key_reg;
        we          = 1'b0;
        wa          = slot_reg;
        wd          = '0;

        case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                wa       = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (q_nonempty)
                begin
                    q_pop     = 1'b1;
                    op_next   = q_data.op;
                    key_next  = q_data.key;
                    addr_next = q_data.addr;
                    len_next  = (q_data.op == OP_LOOKUP) ? MAX_LEN : q_data.len;
                    mlen_next = '0;
                    mod_din   = q_data.key;
                    case (q_data.op)
                        OP_BADLEN:
                        begin
                            status_next = ST_BADLEN;
                            state_next  = S_OUT;
                        end
                        OP_NOP:
                        begin
                            status_next = ST_MISS;
                            state_next  = S_OUT;
                        end
                        OP_INSERT:
                        begin
                            if (cnt_reg >= HALF)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_OUT;
                            end
                            else
                            begin
                                mod_start  = 1'b1;
                                state_next = S_MOD;
                            end
                        end
                        default:
                        begin
                            mod_start  = 1'b1;
                            state_next = S_MOD;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    slot_next  = mod_rem;
                    n_next     = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
                state_next = S_CHK;
            S_CHK:
            begin
                slot_next  = slot_inc;
                n_next     = n_reg + 1'b1;
                state_next = S_RD;
                case (op_reg)
                    OP_LOOKUP:
                    begin
                        if (rd_v && key_hit)
                        begin
                            status_next = ST_OK;
                            mlen_next   = rd_len;
                            state_next  = S_OUT;
                        end
                        else if (!rd_v || n_reg == LAST)
                        begin
                            if (len_reg == '0)
                            begin
                                status_next = ST_MISS;
                                state_next  = S_OUT;
                            end
                            else
                            begin
                                len_next   = len_dec;
                                key_next   = lookup_key(addr_reg, len_dec);
                                mod_din    = key_next;
                                mod_start  = 1'b1;
                                state_next = S_MOD;
                            end
                        end
                    end
                    OP_INSERT:
                    begin
                        if (!rd_v)
                        begin
                            we          = 1'b1;
                            wd          = {1'b1, len_reg, key_reg};
                            cnt_next    = cnt_reg + 1'b1;
                            status_next = ST_OK;
                            state_next  = S_OUT;
                        end
                        else if (key_hit)
                        begin
                            status_next = ST_MISS;
                            state_next  = S_OUT;
                        end
                        else if (n_reg == LAST)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_OUT;
                        end
                    end
                    default:
                    begin
                        if (rd_v && key_hit)
                        begin
                            we          = 1'b1;
                            cnt_next    = (cnt_reg != '0) ? cnt_reg - 1'b1 : cnt_reg;
                            status_next = ST_OK;
                            state_next  = S_OUT;
                        end
                        else if (n_reg == LAST)
                        begin
                            status_next = ST_MISS;
                            state_next  = S_OUT;
                        end
                    end
                endcase
            end
            S_OUT:
            begin
                if (rsp.ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        addr_reg   <= addr_next;
        len_reg    <= len_next;
        slot_reg   <= slot_next;
        n_reg      <= n_next;
        status_reg <= status_next;
        mlen_reg   <= mlen_next;
    end

    // slot memory: valid, length, key
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[slot_reg];
    end

    assign rsp.valid     = (state_reg == S_OUT);
    assign rsp.status    = status_reg;
    assign rsp.match_len = mlen_reg;

endmodule
